// File: rtl/brcs_pkg.sv
// Package for the banked RAM card switch: bus kind codes, address constants and
// the structs that pass between the control and memory blocks. No dependencies.
package brcs_pkg;

    localparam logic [1:0] KIND_SWITCH = 2'd0;
    localparam logic [1:0] KIND_READ   = 2'd1;
    localparam logic [1:0] KIND_WRITE  = 2'd2;

    localparam logic [15:0] WINDOW_BASE = 16'hD000;
    localparam logic [15:0] UPPER_BASE  = 16'hE000;

    localparam int MEM_AW = 13;

    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic              upper;
        logic [MEM_AW-1:0] idx;
        logic [7:0]        wdata;
    } mem_req_t;

    typedef struct packed {
        logic served;
        logic is_read;
    } rsp_info_t;

endpackage

// File: rtl/brcs_req_if.sv
// Request channel of the banked RAM card switch: valid/ready with the bus
// access payload. No dependencies.
interface brcs_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [15:0] address;
    logic [7:0]  write_data;

    modport source (output valid, kind, address, write_data, input ready);
    modport sink   (input valid, kind, address, write_data, output ready);
endinterface

// File: rtl/brcs_rsp_if.sv
// Response channel of the banked RAM card switch: valid/ready with the read
// data and served flag. No dependencies.
interface brcs_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       served;

    modport source (output valid, read_data, served, input ready);
    modport sink   (input valid, read_data, served, output ready);
endinterface

// File: rtl/brcs_mem.sv
// Upper RAM and lower bank RAM, each 8K x 8, synchronous with a registered read,
// plus the clearing pass after reset. Depends on brcs_pkg.
module brcs_mem (
    input  logic               clk,
    input  logic               rst_n,
    input  brcs_pkg::mem_req_t req,
    output logic [7:0]         rdata,
    output logic               ready
);

    localparam int DEPTH = 1 << brcs_pkg::MEM_AW;

    logic [7:0] upper_mem [DEPTH];
    logic [7:0] lower_mem [DEPTH];

    logic                       busy_reg;
    logic                       busy_next;
    logic [brcs_pkg::MEM_AW-1:0] clr_cnt_reg;
    logic [brcs_pkg::MEM_AW-1:0] clr_cnt_next;

    logic [7:0] upper_rd_reg;
    logic [7:0] lower_rd_reg;
    logic       sel_upper_reg;

    always_comb
    begin
        busy_next    = busy_reg;
        clr_cnt_next = clr_cnt_reg;
        if (busy_reg)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (&clr_cnt_reg)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b1;
            clr_cnt_reg <= '0;
        end
        else
        begin
            busy_reg    <= busy_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
            upper_mem[clr_cnt_reg] <= 8'd0;
        else if (req.wr_en && req.upper)
            upper_mem[req.idx] <= req.wdata;
        if (req.rd_en && req.upper)
            upper_rd_reg <= upper_mem[req.idx];
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
            lower_mem[clr_cnt_reg] <= 8'd0;
        else if (req.wr_en && !req.upper)
            lower_mem[req.idx] <= req.wdata;
        if (req.rd_en && !req.upper)
            lower_rd_reg <= lower_mem[req.idx];
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
            sel_upper_reg <= req.upper;
    end

    assign rdata = sel_upper_reg ? upper_rd_reg : lower_rd_reg;
    assign ready = !busy_reg;

endmodule

// File: rtl/brcs_ctrl.sv
// Mode registers (bank select, read/write enables, equal-bits history) and the
// decode of one accepted bus access into a RAM request. Depends on brcs_pkg.
module brcs_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [1:0]          kind,
    input  logic [15:0]         address,
    input  logic [7:0]          write_data,
    output brcs_pkg::mem_req_t  mem_req,
    output brcs_pkg::rsp_info_t info
);

    logic bank_reg,  bank_next;
    logic read_reg,  read_next;
    logic write_reg, write_next;
    logic hist_reg,  hist_next;

    logic [3:0] c;
    logic       in_window;
    logic       upper;

    assign c         = address[3:0];
    assign in_window = address >= brcs_pkg::WINDOW_BASE;
    assign upper     = address >= brcs_pkg::UPPER_BASE;

    always_comb
    begin
        bank_next  = bank_reg;
        read_next  = read_reg;
        write_next = write_reg;
        hist_next  = hist_reg;
        case (kind)
            brcs_pkg::KIND_SWITCH:
            begin
                write_next = c[0];
                if (c[1] == c[0])
                begin
                    if (hist_reg)
                        read_next = 1'b1;
                    hist_next = 1'b1;
                end
                else
                begin
                    read_next = 1'b0;
                    hist_next = 1'b0;
                end
                bank_next = ~c[3];
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        info.served    = 1'b0;
        info.is_read   = 1'b0;
        mem_req.rd_en  = 1'b0;
        mem_req.wr_en  = 1'b0;
        mem_req.upper  = upper;
        mem_req.idx    = upper ? address[brcs_pkg::MEM_AW-1:0] : {bank_reg, address[11:0]};
        mem_req.wdata  = write_data;
        case (kind)
            brcs_pkg::KIND_READ:
            begin
                info.is_read = 1'b1;
                if (in_window && read_reg)
                begin
                    info.served   = 1'b1;
                    mem_req.rd_en = accept;
                end
            end
            brcs_pkg::KIND_WRITE:
            begin
                if (in_window && write_reg)
                begin
                    info.served   = 1'b1;
                    mem_req.wr_en = accept;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_reg  <= 1'b0;
            read_reg  <= 1'b0;
            write_reg <= 1'b0;
            hist_reg  <= 1'b0;
        end
        else if (accept)
        begin
            bank_reg  <= bank_next;
            read_reg  <= read_next;
            write_reg <= write_next;
            hist_reg  <= hist_next;
        end
    end

endmodule

// File: rtl/banked_ram_card_switch_unit.sv
// Top level of the banked RAM card switch: request/response channels, result
// register. Depends on brcs_pkg, brcs_req_if, brcs_rsp_if, brcs_ctrl, brcs_mem.
//
// Bank-switched RAM card for 0xD000-0xFFFF: 8 KB fixed upper RAM plus two 4 KB
// lower banks. After reset the RAMs are cleared one entry per cycle, upper and
// lower in parallel; no request is taken during that pass. Afterwards one
// transfer is taken per cycle: the access is decoded and the RAM written or
// read at accept, and the result appears in the next cycle from the registered
// RAM read port. A new request is taken in the same cycle the previous result
// is transferred; a stalled result stalls the request side.
module banked_ram_card_switch_unit (
    input  logic   clk,
    input  logic   rst_n,
    brcs_req_if.sink   req,
    brcs_rsp_if.source rsp
);

    brcs_pkg::mem_req_t  mem_req;
    brcs_pkg::rsp_info_t info;
    logic [7:0]          mem_rdata;
    logic                mem_ready;
    logic                accept;

    logic out_valid_reg, out_valid_next;
    logic served_reg;
    logic is_read_reg;

    assign req.ready = mem_ready && (!out_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;

    brcs_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .kind       (req.kind),
        .address    (req.address),
        .write_data (req.write_data),
        .mem_req    (mem_req),
        .info       (info)
    );

    brcs_mem u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mem_req),
        .rdata (mem_rdata),
        .ready (mem_ready)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            served_reg  <= info.served;
            is_read_reg <= info.is_read;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.served    = served_reg;
    assign rsp.read_data = (served_reg && is_read_reg) ? mem_rdata : 8'd0;

endmodule
